FILE: rtl/pi4_pkg.sv
`timescale 1ns / 1ps

package pi4_pkg;

    localparam int PALETTE_SIZE_DEF = 16;
    localparam int NIB_W            = 4;
    localparam int ARGB_W           = 16;
    localparam int PIXEL_W          = 32;
    localparam int BYTE_W           = 8;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_rgba;
        logic               last_of_image;
    } t_pixel_in;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              byte_valid;
        logic              new_colour_valid;
        logic [NIB_W-1:0]  new_colour_slot;
        logic [ARGB_W-1:0] new_colour_argb4444;
        logic              overflow;
    } t_pixel_out;

    // keep the top nibble of each channel, alpha moves to the top
    function automatic logic [ARGB_W-1:0] to_argb4444(input logic [PIXEL_W-1:0] px);
        to_argb4444 = {px[7:4], px[31:28], px[23:20], px[15:12]};
    endfunction

endpackage

FILE: rtl/palette_indexer_4bpp.sv
`timescale 1ns / 1ps

// Palette indexer: each RGBA8888 pixel is cut to ARGB4444 and looked up in a
// palette of PALETTE_SIZE slots (2 to 16) filled in order of first appearance;
// new colours are reported with their slot, and indices leave packed two per
// byte, even pixel in the high nibble. A full palette sets a sticky overflow
// flag and maps the pixel to index 0. A pixel marked last flushes any half
// byte and clears the palette, counts and flag. One pixel is taken every
// cycle while the output is not stalled; each result passes the input
// register, then the result register, and the parallel compare against all
// slots plus the insert of a new colour sits between those two registers.
module palette_indexer_4bpp #(
    parameter int PALETTE_SIZE = pi4_pkg::PALETTE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pi4_pkg::t_pixel_in i_pixel,
    output logic               o_valid,
    input  logic               i_stall,
    output pi4_pkg::t_pixel_out o_result
);
    import pi4_pkg::*;

    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);

    logic              r_in_valid;
    t_pixel_in         r_in;
    logic              r_out_valid;
    t_pixel_out        r_out;

    logic [ARGB_W-1:0] r_pal [PALETTE_SIZE];
    logic [CNT_W-1:0]  r_count;
    logic [NIB_W-1:0]  r_pending;
    logic              r_odd;
    logic              r_ovf;

    logic              in_xfer;
    logic              out_ready;
    logic              fire;
    logic [ARGB_W-1:0] colour;
    logic              found;
    logic [NIB_W-1:0]  match_idx;
    logic              room;
    logic              add_new;
    logic              ovf_now;
    logic [NIB_W-1:0]  idx;
    t_pixel_out        n_out;
    logic [CNT_W-1:0]  n_count;
    logic [NIB_W-1:0]  n_pending;
    logic              n_odd;
    logic              n_ovf;

    assign out_ready = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !out_ready;
    assign in_xfer   = i_valid && !o_stall;
    assign fire      = r_in_valid && out_ready;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    assign colour = to_argb4444(r_in.pixel_rgba);

    // lowest valid slot that matches wins
    always_comb begin
        found     = 1'b0;
        match_idx = '0;
        for (int j = PALETTE_SIZE - 1; j >= 0; j--) begin
            if ((CNT_W'(j) < r_count) && (r_pal[j] == colour)) begin
                found     = 1'b1;
                match_idx = NIB_W'(j);
            end
        end
    end

    assign room    = r_count < CNT_W'(PALETTE_SIZE);
    assign add_new = !found && room;
    assign ovf_now = !found && !room;
    assign idx     = found ? match_idx : (add_new ? NIB_W'(r_count) : '0);

    always_comb begin
        n_out           = '0;
        n_out.overflow  = r_ovf || ovf_now;
        if (add_new) begin
            n_out.new_colour_valid    = 1'b1;
            n_out.new_colour_slot     = NIB_W'(r_count);
            n_out.new_colour_argb4444 = colour;
        end
        n_pending = r_pending;
        n_odd     = r_odd;
        if (r_odd) begin
            n_out.packed_byte = {r_pending, idx};
            n_out.byte_valid  = 1'b1;
            n_odd             = 1'b0;
            n_pending         = '0;
        end else if (r_in.last_of_image) begin
            n_out.packed_byte = {idx, {NIB_W{1'b0}}};
            n_out.byte_valid  = 1'b1;
        end else begin
            n_pending = idx;
            n_odd     = 1'b1;
        end
        n_count = add_new ? r_count + 1'b1 : r_count;
        n_ovf   = r_ovf || ovf_now;
        // end of image wipes the per-image state
        if (r_in.last_of_image) begin
            n_count   = '0;
            n_pending = '0;
            n_odd     = 1'b0;
            n_ovf     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_pending   <= '0;
            r_odd       <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (out_ready) begin
                r_in_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_count   <= n_count;
                r_pending <= n_pending;
                r_odd     <= n_odd;
                r_ovf     <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_pixel;
        end
        if (fire) begin
            r_out <= n_out;
        end
        for (int j = 0; j < PALETTE_SIZE; j++) begin
            if (fire && add_new && (r_count == CNT_W'(j))) begin
                r_pal[j] <= colour;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PALETTE_SIZE))
        else $error("palette count above palette size");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.last_of_image |=> r_count == '0 && !r_odd && !r_ovf)
        else $error("per-image state not cleared after last pixel");

    a_new_vs_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && add_new && !r_in.last_of_image |=>
            r_out.new_colour_valid && (r_count != '0))
        else $error("new colour not reported or not counted");

    a_odd_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_odd |=> r_out.byte_valid && !r_odd)
        else $error("odd pixel did not complete a byte");
`endif

endmodule
